// ===== design/ale_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ale_pkg
// Shared types and constants for the array list engine: word formats,
// command and status codes, and the controller to datapath interface.
// ----------------------------------------------------------------------------
package ale_pkg;

    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CMD_BITS  = 3;
    localparam int POS_BITS  = 7;
    localparam int STAT_BITS = 2;
    localparam int CMP_W     = POS_BITS + 1;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_INSERT = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_READ   = 3'd2,
        CMD_UPDATE = 3'd3,
        CMD_CLEAR  = 3'd4
    } cmd_e_t;

    typedef enum logic [STAT_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_e_t;

    typedef enum logic [1:0] {
        RD_POS,
        RD_BELOW,
        RD_ABOVE
    } rd_sel_t;

    typedef enum logic {
        WR_SHIFT,
        WR_NEW
    } wr_sel_t;

    typedef struct packed {
        logic [CMD_BITS-1:0]  cmd;
        logic [POS_BITS-1:0]  position;
        logic [WORD_BITS-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] value_out;
        logic [STAT_BITS-1:0] status;
        logic [CNT_W-1:0]     count;
    } out_word_t;

    typedef struct packed {
        logic    load_in;
        logic    idx_load_count;
        logic    idx_load_pos;
        logic    idx_dec;
        logic    idx_inc;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    cap_vout;
        logic    load_out;
    } ctl_t;

    typedef struct packed {
        logic is_insert;
        logic is_remove;
        logic is_read;
        logic is_update;
        logic range_err;
        logic full_err;
        logic ins_shift_first;
        logic rem_shift_first;
        logic ins_more;
        logic rem_more;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

// ===== design/ale_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ale_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module ale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== design/ale_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ale_ctrl
// Command sequencer. Checks each command, walks the entry shifts one
// read and one write at a time, and hands the result to the output register.
// ----------------------------------------------------------------------------
module ale_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire ale_pkg::dp_status_t st,
    output ale_pkg::ctl_t           ctl
);
    import ale_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_RD,
        S_CAP,
        S_SH_RD,
        S_SH_WR,
        S_WR_WORD,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        ctl        = '0;
        ctl.rd_sel = RD_POS;
        ctl.wr_sel = WR_SHIFT;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    ctl.load_in = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL: begin
                priority if (st.range_err || st.full_err) begin
                    state_next = S_DONE;
                end else if (st.is_insert) begin
                    ctl.idx_load_count = 1'b1;
                    state_next = st.ins_shift_first ? S_SH_RD : S_WR_WORD;
                end else if (st.is_remove || st.is_read || st.is_update) begin
                    state_next = S_RD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_RD: begin
                ctl.rd_en  = 1'b1;
                ctl.rd_sel = RD_POS;
                state_next = S_CAP;
            end
            S_CAP: begin
                ctl.cap_vout = 1'b1;
                priority if (st.is_update) begin
                    state_next = S_WR_WORD;
                end else if (st.is_remove) begin
                    ctl.idx_load_pos = 1'b1;
                    state_next = st.rem_shift_first ? S_SH_RD : S_DONE;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_SH_RD: begin
                ctl.rd_en  = 1'b1;
                ctl.rd_sel = st.is_insert ? RD_BELOW : RD_ABOVE;
                state_next = S_SH_WR;
            end
            S_SH_WR: begin
                ctl.wr_en  = 1'b1;
                ctl.wr_sel = WR_SHIFT;
                if (st.is_insert) begin
                    ctl.idx_dec = 1'b1;
                    state_next  = st.ins_more ? S_SH_RD : S_WR_WORD;
                end else begin
                    ctl.idx_inc = 1'b1;
                    state_next  = st.rem_more ? S_SH_RD : S_DONE;
                end
            end
            S_WR_WORD: begin
                ctl.wr_en  = 1'b1;
                ctl.wr_sel = WR_NEW;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (st.out_free) begin
                    ctl.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_shift_cmd_known: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SH_RD) |-> (st.is_insert || st.is_remove))
        else $error("shift started for a command that does not shift");

    a_done_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) |-> !ctl.wr_en && !ctl.rd_en)
        else $error("storage access while a result is pending");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.load_in |=> (state_reg == S_EVAL))
        else $error("accepted word did not reach evaluation");

endmodule
`default_nettype wire

// ===== design/ale_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ale_datapath
// Entry storage, entry count, command holding registers, shift index and
// the output register of the array list engine.
// ----------------------------------------------------------------------------
module ale_datapath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire ale_pkg::in_word_t   s_data,
    input  wire ale_pkg::ctl_t       ctl,
    output ale_pkg::dp_status_t      st,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output ale_pkg::out_word_t       m_data
);
    import ale_pkg::*;

    logic [CMD_BITS-1:0]  cmd_reg;
    logic [POS_BITS-1:0]  pos_reg;
    logic [WORD_BITS-1:0] word_reg;
    logic [CNT_W-1:0]     idx_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [WORD_BITS-1:0] vout_reg;
    out_word_t            out_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;

    logic [CMP_W-1:0]     pos_w;
    logic [CMP_W-1:0]     cnt_w;
    logic [CMP_W-1:0]     idx_w;
    logic                 ins_range;
    logic                 oth_range;
    logic                 is_clear;
    logic [CNT_W-1:0]     idx_below;
    logic [CNT_W-1:0]     idx_above;
    logic [ADDR_W-1:0]    raddr;
    logic [ADDR_W-1:0]    waddr;
    logic [WORD_BITS-1:0] wdata;
    logic [WORD_BITS-1:0] rdata;
    status_e_t            result_status;

    assign pos_w = CMP_W'(pos_reg);
    assign cnt_w = CMP_W'(count_reg);
    assign idx_w = CMP_W'(idx_reg);

    assign st.is_insert = (cmd_reg == CMD_INSERT);
    assign st.is_remove = (cmd_reg == CMD_REMOVE);
    assign st.is_read   = (cmd_reg == CMD_READ);
    assign st.is_update = (cmd_reg == CMD_UPDATE);
    assign is_clear     = (cmd_reg == CMD_CLEAR);

    assign ins_range = pos_w > cnt_w;
    assign oth_range = pos_w >= cnt_w;

    assign st.range_err = st.is_insert ? ins_range
                        : ((st.is_remove || st.is_read || st.is_update) && oth_range);
    assign st.full_err  = st.is_insert && !ins_range && (cnt_w >= CMP_W'(DEPTH));

    assign st.ins_shift_first = cnt_w > pos_w;
    assign st.rem_shift_first = (pos_w + CMP_W'(1)) < cnt_w;
    assign st.ins_more        = idx_w > (pos_w + CMP_W'(1));
    assign st.rem_more        = (idx_w + CMP_W'(2)) < cnt_w;
    assign st.out_free        = !out_valid_reg || m_ready;

    assign idx_below = idx_reg - CNT_W'(1);
    assign idx_above = idx_reg + CNT_W'(1);

    always_comb begin
        unique case (ctl.rd_sel)
            RD_BELOW: raddr = idx_below[ADDR_W-1:0];
            RD_ABOVE: raddr = idx_above[ADDR_W-1:0];
            default:  raddr = pos_reg[ADDR_W-1:0];
        endcase
    end

    always_comb begin
        unique case (ctl.wr_sel)
            WR_NEW: begin
                waddr = pos_reg[ADDR_W-1:0];
                wdata = word_reg;
            end
            default: begin
                waddr = idx_reg[ADDR_W-1:0];
                wdata = rdata;
            end
        endcase
    end

    ale_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_entries (
        .aclk  (aclk),
        .we    (ctl.wr_en),
        .waddr (waddr),
        .wdata (wdata),
        .re    (ctl.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb begin
        priority if (st.range_err) begin
            result_status = ST_RANGE;
        end else if (st.full_err) begin
            result_status = ST_FULL;
        end else begin
            result_status = ST_OK;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (ctl.load_out) begin
            priority if (is_clear) begin
                count_next = '0;
            end else if (st.is_insert && !st.range_err && !st.full_err) begin
                count_next = count_reg + CNT_W'(1);
            end else if (st.is_remove && !st.range_err) begin
                count_next = count_reg - CNT_W'(1);
            end else begin
                count_next = count_reg;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (ctl.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_in) begin
            cmd_reg  <= s_data.cmd;
            pos_reg  <= s_data.position;
            word_reg <= s_data.value;
        end
        if (ctl.load_in) begin
            vout_reg <= '0;
        end else if (ctl.cap_vout) begin
            vout_reg <= rdata;
        end
        priority if (ctl.idx_load_count) begin
            idx_reg <= count_reg;
        end else if (ctl.idx_load_pos) begin
            idx_reg <= pos_reg[CNT_W-1:0];
        end else if (ctl.idx_dec) begin
            idx_reg <= idx_below;
        end else if (ctl.idx_inc) begin
            idx_reg <= idx_above;
        end else begin
            idx_reg <= idx_reg;
        end
        if (ctl.load_out) begin
            out_reg.value_out <= vout_reg;
            out_reg.status    <= result_status;
            out_reg.count     <= count_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above list depth");

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctl.rd_en && ctl.wr_en))
        else $error("read and write of entry storage in one cycle");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.load_out && st.is_insert && !st.range_err && !st.full_err)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("successful insert did not grow the list");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.load_out |-> st.out_free)
        else $error("result overwrote an untaken word");

endmodule
`default_nettype wire

// ===== design/array_list_engine.sv =====
`default_nettype none
// The engine takes one command at a time. Clear, unused commands and rejected
// commands go straight to the result; read does one entry read, update a read
// and then a write. Insert and remove move entries one by one: each moved entry
// costs one read and one write on the single entry RAM.
// Reset clears the entry count and the output valid flag; the entry RAM is not
// cleared and holds nothing readable until written.
// ----------------------------------------------------------------------------
// array_list_engine
// Dense ordered list of words with insert, remove, read, update and clear
// commands, each answered with one result word.
// ----------------------------------------------------------------------------
module array_list_engine (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire ale_pkg::in_word_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output ale_pkg::out_word_t      m_data
);
    import ale_pkg::*;

    ctl_t       ctl;
    dp_status_t st;

    ale_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .ctl     (ctl)
    );

    ale_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .ctl     (ctl),
        .st      (st),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

// ===== bench/array_list_engine_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_engine_tb
// Drives insert, remove, read, update, clear and unused commands into the
// list engine through random bursts and receiver stalls. It checks every
// result word against a behavioral list kept inside the scoreboard.
// ----------------------------------------------------------------------------
module array_list_engine_tb;

    import ale_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 1100;

    // Behavioral copy of the list. Every accepted command word is applied here
    // and its answer is queued until the engine returns the matching result.
    class list_scoreboard;
        logic [WORD_BITS-1:0] words [DEPTH];
        int                   n_entries;
        out_word_t            due_answers [$];
        int                   mismatches;

        function new();
            n_entries  = 0;
            mismatches = 0;
        endfunction

        function void log_command(in_word_t w);
            out_word_t ans;
            int        p;
            int        i;
            ans           = '0;
            ans.status    = ST_OK;
            p             = w.position;
            case (w.cmd)
                CMD_INSERT: begin
                    if (p > n_entries) begin
                        ans.status = ST_RANGE;
                    end else if (n_entries >= DEPTH) begin
                        ans.status = ST_FULL;
                    end else begin
                        for (i = n_entries; i > p; i--) words[i] = words[i-1];
                        words[p] = w.value;
                        n_entries++;
                    end
                end
                CMD_REMOVE: begin
                    if (p >= n_entries) begin
                        ans.status = ST_RANGE;
                    end else begin
                        ans.value_out = words[p];
                        for (i = p; i + 1 < n_entries; i++) words[i] = words[i+1];
                        n_entries--;
                    end
                end
                CMD_READ: begin
                    if (p >= n_entries) ans.status = ST_RANGE;
                    else ans.value_out = words[p];
                end
                CMD_UPDATE: begin
                    if (p >= n_entries) begin
                        ans.status = ST_RANGE;
                    end else begin
                        ans.value_out = words[p];
                        words[p]      = w.value;
                    end
                end
                CMD_CLEAR: begin
                    n_entries = 0;
                end
                default: begin
                end
            endcase
            ans.count = n_entries[CNT_W-1:0];
            due_answers.push_back(ans);
        endfunction

        function void check_answer(out_word_t got);
            out_word_t want;
            if (due_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: value_out %h status %0d count %0d",
                             got.value_out, got.status, got.count);
            end else begin
                want = due_answers.pop_front();
                if (got.value_out !== want.value_out || got.status !== want.status ||
                    got.count !== want.count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                                 want.value_out, want.status, want.count,
                                 got.value_out, got.status, got.count);
                end
            end
        endfunction

        function int pending();
            return due_answers.size();
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    list_scoreboard sb;
    int             cycle_cnt = 0;
    int             burst_left = 0;
    int             stretch_left = 0;
    int             stall_pct = 0;
    bit             growing = 1'b1;
    int             full_visits = 0;

    array_list_engine u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("array_list_engine_tb: FAIL");
        $finish;
    end

    // The receiver stalls in stretches, each with its own stall rate.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (stretch_left == 0) begin
                stretch_left = $urandom_range(256, 32);
                case ($urandom_range(3, 0))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            stretch_left--;
            m_ready <= ($urandom_range(99, 0) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_answer(m_data);
    end

    task automatic send_word(input in_word_t w);
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        sb.log_command(w);
    endtask

    task automatic pace();
        int gap;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(24, 1);
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic issue(input logic [CMD_BITS-1:0] c, input int p,
                         input logic [WORD_BITS-1:0] v);
        in_word_t w;
        w.cmd      = c;
        w.position = p[POS_BITS-1:0];
        w.value    = v;
        send_word(w);
        pace();
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // Picks a position that is mostly legal for the command, favoring both
    // ends of the list, with some positions anywhere in the field's range.
    function automatic int pick_position(input logic [CMD_BITS-1:0] c, input int n);
        int top;
        top = (c == CMD_INSERT) ? n : n - 1;
        if (top < 0 || $urandom_range(9, 0) == 0) return $urandom_range(127, 0);
        case ($urandom_range(4, 0))
            0: return 0;
            1: return top;
            default: return $urandom_range(top, 0);
        endcase
    endfunction

    function automatic logic [WORD_BITS-1:0] pick_value();
        case ($urandom_range(15, 0))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Grows the list until it has been seen full a few times, then shrinks
    // it until it is empty, so that both ends are reached repeatedly.
    task automatic random_command();
        logic [CMD_BITS-1:0] c;
        int                  r;
        if (growing && sb.n_entries == DEPTH) begin
            full_visits++;
            if (full_visits > 4) growing = 1'b0;
        end else if (!growing && sb.n_entries == 0) begin
            growing     = 1'b1;
            full_visits = 0;
        end
        r = $urandom_range(99, 0);
        if (growing) begin
            if (r < 60) c = CMD_INSERT;
            else if (r < 72) c = CMD_REMOVE;
            else if (r < 84) c = CMD_READ;
            else if (r < 96) c = CMD_UPDATE;
            else c = 3'($urandom_range(7, 5));
        end else begin
            if (r < 55) c = CMD_REMOVE;
            else if (r < 67) c = CMD_INSERT;
            else if (r < 81) c = CMD_READ;
            else if (r < 95) c = CMD_UPDATE;
            else if (r < 97) c = CMD_CLEAR;
            else c = 3'($urandom_range(7, 5));
        end
        issue(c, pick_position(c, sb.n_entries), pick_value());
    endtask

    initial begin
        sb      = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        issue(CMD_READ,   0,   32'h0000_0000);
        issue(CMD_REMOVE, 0,   32'h0000_0000);
        issue(CMD_UPDATE, 0,   32'hFFFF_FFFF);
        issue(CMD_INSERT, 1,   32'h1111_1111);
        issue(CMD_INSERT, 0,   32'hFFFF_FFFF);
        issue(CMD_INSERT, 1,   32'h0000_0000);
        issue(CMD_INSERT, 0,   32'hA5A5_A5A5);
        issue(CMD_INSERT, 1,   32'h5A5A_5A5A);
        issue(CMD_READ,   3,   32'h0000_0000);
        issue(CMD_READ,   4,   32'h0000_0000);
        issue(CMD_UPDATE, 0,   32'h1234_5678);
        issue(CMD_REMOVE, 1,   32'h0000_0000);
        issue(CMD_REMOVE, 2,   32'h0000_0000);
        issue(CMD_READ,   127, 32'h0000_0000);
        issue(CMD_INSERT, 127, 32'hFFFF_FFFF);
        issue(3'd5,       0,   32'hFFFF_FFFF);
        issue(3'd6,       1,   32'hFFFF_FFFF);
        issue(3'd7,       127, 32'hFFFF_FFFF);
        issue(CMD_UPDATE, 2,   32'hFFFF_FFFF);
        issue(CMD_CLEAR,  0,   32'h0000_0000);
        issue(CMD_READ,   0,   32'h0000_0000);
        issue(CMD_INSERT, 0,   32'hDEAD_BEEF);
        issue(CMD_REMOVE, 0,   32'h0000_0000);
        issue(CMD_REMOVE, 0,   32'h0000_0000);
        drain();

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == RANDOM_ITEMS / 2) drain();
            random_command();
        end
        drain();
        repeat (150) @(posedge aclk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("array_list_engine_tb: PASS");
        end else begin
            $display("array_list_engine_tb: FAIL");
        end
        $finish;
    end

endmodule
